// ===== rtl/core/bvd_pkg.sv =====
// ----------------------------------------------------------------------------
// Block video frame decoder package
// Shared types, block type codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bvd_pkg;

  typedef logic [7:0] pix_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OWN,
    S_SRC_L,
    S_SRC_R,
    S_WR,
    S_DONE
  } state_t;

  localparam logic [5:0] CMD_SKIP     = 6'd0;
  localparam logic [5:0] CMD_MASKED   = 6'd1;
  localparam logic [5:0] CMD_SOLID    = 6'd2;
  localparam logic [5:0] CMD_RAW      = 6'd3;
  localparam logic [5:0] CMD_MOTION   = 6'd4;
  localparam logic [5:0] CMD_SKIP_ALT = 6'd5;
  localparam logic [5:0] CMD_QUAD     = 6'd8;
  localparam logic [5:0] CMD_CMP_0    = 6'd10;
  localparam logic [5:0] CMD_CMP_1    = 6'd11;
  localparam logic [5:0] CMD_CMP_2    = 6'd12;
  localparam logic [5:0] CMD_CMP_3    = 6'd13;
  localparam logic [5:0] CMD_CMP_4    = 6'd14;
  localparam logic [5:0] CMD_CMP_5    = 6'd15;
  localparam logic [5:0] CMD_PAL_2    = 6'd32;
  localparam logic [5:0] CMD_PAL_3    = 6'd33;
  localparam logic [5:0] CMD_PAL_4    = 6'd34;

  localparam logic [1:0] QS_SKIP   = 2'b00;
  localparam logic [1:0] QS_SOLID  = 2'b01;
  localparam logic [1:0] QS_MOTION = 2'b10;
  localparam logic [1:0] QS_RAW    = 2'b11;

  localparam logic [3:0] CMP_SHIFT_HI [0:5] = '{4'd0, 4'd8, 4'd8, 4'd8, 4'd4, 4'd4};
  localparam logic [3:0] CMP_SHIFT_LO [0:5] = '{4'd0, 4'd0, 4'd8, 4'd4, 4'd0, 4'd4};

  typedef struct packed {
    logic [5:0]  cmd;
    logic [15:0] map;
    logic [31:0] mask;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  qsel;
    logic [15:0] qdp;
  } item_t;

  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] prev;
    logic [15:0] tag;
  } word_rd_t;

  typedef struct packed {
    logic        cur_we;
    logic        prev_we;
    logic [31:0] cur_d;
    logic [31:0] prev_d;
    logic [15:0] tag_d;
  } wr_ctl_t;

  function automatic pix_t data_byte(logic [63:0] lo, logic [63:0] hi, logic [3:0] k);
    pix_t b;
    if (k[3]) begin
      b = hi[{k[2:0], 3'b000} +: 8];
    end else begin
      b = lo[{k[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  function automatic logic [15:0] compact_map(logic [5:0] cmd, logic [7:0] b);
    logic [3:0]  idx;
    logic [31:0] hi_part;
    logic [31:0] lo_part;
    logic [15:0] m;
    idx = cmd[3:0] - 4'd10;
    m   = '0;
    if (idx < 4'd6) begin
      hi_part = {24'd0, b & 8'hF0} << CMP_SHIFT_HI[idx[2:0]];
      lo_part = {24'd0, b & 8'h0F} << CMP_SHIFT_LO[idx[2:0]];
      m = hi_part[15:0] | lo_part[15:0];
    end
    return m;
  endfunction

  function automatic logic [15:0] resolve_pair(word_rd_t a, word_rd_t b, logic [15:0] ep,
                                               logic [1:0] off, logic v0, logic v1);
    logic [31:0] va;
    logic [31:0] vb;
    logic [63:0] both;
    logic [15:0] r;
    va   = (a.tag == ep) ? a.prev : a.cur;
    vb   = (b.tag == ep) ? b.prev : b.cur;
    both = {vb, va};
    r    = both[{off, 3'b000} +: 16];
    if (!v0) begin
      r[7:0] = 8'd0;
    end
    if (!v1) begin
      r[15:8] = 8'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/block_video_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// Block video frame decoder
// Rebuilds an 8-bit frame from coded 4x4 block items in raster block order.
// ----------------------------------------------------------------------------
// Usage: each input item (in_valid, in_stall) carries one coded block; one
// result item (out_valid, out_stall) follows with the block's position and
// its sixteen pixels after the update. Registers are written on cfg_we with
// cfg_index 0 for the width and 1 for the height in blocks.
// A result item becomes valid once its block has passed, row by row, through
// S_OWN, S_SRC_L, S_SRC_R and S_WR and then through S_DONE: four pixel lanes
// handle one block row at a time, and each row needs these states because the
// frame memory has two read ports and a row needs its own word plus up to
// four source words for motion copies. Items are taken one at a time.
// The saved frame is kept by per-word epoch tags: a word keeps its old value
// in the saved store the first time it is rewritten in a frame.
// After reset the block clears all MAX_WIDTH*MAX_HEIGHT/4 words (76800 by
// default) of the frame memory, one word a cycle, and holds in_stall high.
// When the receiver stalls, the result waits in the output register; the
// block still takes one more item and holds its result until the register
// frees.
// ----------------------------------------------------------------------------
`default_nettype none

module block_video_frame_decoder #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_cmd,
  input  logic [31:0] in_mask,
  input  logic [63:0] in_data_lo,
  input  logic [63:0] in_data_hi,
  input  logic [31:0] in_motion,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_block_col,
  output logic [6:0]  out_block_row,
  output logic [63:0] out_pixels_lo,
  output logic [63:0] out_pixels_hi,
  output logic        out_bad_type,
  output logic        out_last_of_frame
);
  import bvd_pkg::*;

  localparam int WORDS  = MAX_WIDTH * MAX_HEIGHT / 4;
  localparam int AW     = $clog2(WORDS);
  localparam int MAX_BW = MAX_WIDTH / 4;
  localparam int MAX_BH = MAX_HEIGHT / 4;

  state_t state_r, state_nxt;

  logic [7:0]   bw_cfg_r;
  logic [6:0]   bh_cfg_r;
  logic [7:0]   col_r;
  logic [6:0]   row_r;
  logic [7:0]   bw_r;
  logic [6:0]   bh_r;
  logic [7:0]   cur_col_r;
  logic [6:0]   cur_row_r;
  logic [15:0]  epoch_r;
  item_t        item_r;
  logic [31:0]  qmot_r;
  logic         bad_r;
  logic [1:0]   blk_row_r;
  word_rd_t     own_r;
  logic [15:0]  left_r;
  logic [127:0] pix_r;
  logic [AW-1:0] clr_r;

  logic         out_valid_r;
  logic [7:0]   out_col_r;
  logic [6:0]   out_row_r;
  logic [127:0] out_pix_r;
  logic         out_bad_r;
  logic         out_last_r;

  logic         in_acc;
  logic         out_free;
  logic [7:0]   bw_eff;
  logic [6:0]   bh_eff;
  logic [7:0]   col_eff;
  logic [6:0]   row_eff;
  logic [15:0]  map_in;
  logic [7:0]   qsel_in;
  logic [15:0]  qdp_in;
  logic [31:0]  qmot_in;
  logic         bad_in;

  logic [9:0]   bx;
  logic [8:0]   by;
  logic [9:0]   wpx;
  logic [8:0]   hpx;
  logic signed [11:0] xs_h [2];
  logic signed [11:0] wc_h [2];
  logic signed [10:0] sy_h [2];
  logic [1:0]   off_h [2];
  logic         v0_h [2];
  logic         v1_h [2];

  logic signed [10:0] mul_y;
  logic signed [11:0] mul_x;
  logic signed [19:0] prod;
  logic signed [20:0] addr_s;
  logic signed [20:0] addr_s1;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] wr_addr;
  wr_ctl_t      wr;
  word_rd_t     rd_a;
  word_rd_t     rd_b;
  logic [15:0]  right_pix;
  pix_t         old_pix [4];
  pix_t         src_pix [4];
  pix_t         new_pix [4];
  logic [31:0]  row_word;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_cfg_r <= 8'd80;
      bh_cfg_r <= 7'd50;
    end else if (cfg_we) begin
      if (cfg_index) begin
        bh_cfg_r <= cfg_wdata[6:0];
      end else begin
        bw_cfg_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    logic [1:0] s;
    logic [3:0] dp;
    logic [1:0] mi;
    bw_eff = (bw_cfg_r == 8'd0) ? 8'd1 : ((bw_cfg_r > 8'(MAX_BW)) ? 8'(MAX_BW) : bw_cfg_r);
    bh_eff = (bh_cfg_r == 7'd0) ? 7'd1 : ((bh_cfg_r > 7'(MAX_BH)) ? 7'(MAX_BH) : bh_cfg_r);
    col_eff = (col_r >= bw_eff) ? 8'd0 : col_r;
    row_eff = (row_r >= bh_eff) ? 7'd0 : row_r;
    map_in  = (in_cmd == CMD_MASKED) ? in_mask[15:0] : compact_map(in_cmd, in_mask[7:0]);
    dp = 4'd0;
    mi = 2'd0;
    qsel_in = '0;
    qdp_in  = '0;
    qmot_in = '0;
    for (int q = 0; q < 4; q++) begin
      s = in_mask[7 - 2 * q -: 2];
      qsel_in[2 * q +: 2] = s;
      qdp_in[4 * q +: 4]  = dp;
      qmot_in[8 * q +: 8] = (in_cmd == CMD_MOTION) ? in_motion[7:0] : in_motion[{mi, 3'b000} +: 8];
      if (s == QS_SOLID) begin
        dp = dp + 4'd1;
      end else if (s == QS_RAW) begin
        dp = dp + 4'd4;
      end
      if (s == QS_MOTION) begin
        mi = mi + 2'd1;
      end
    end
    case (in_cmd) inside
      CMD_SKIP, CMD_MASKED, CMD_SOLID, CMD_RAW, CMD_MOTION, CMD_SKIP_ALT, CMD_QUAD,
      CMD_CMP_0, CMD_CMP_1, CMD_CMP_2, CMD_CMP_3, CMD_CMP_4, CMD_CMP_5,
      CMD_PAL_2, CMD_PAL_3, CMD_PAL_4: bad_in = 1'b0;
      default: bad_in = 1'b1;
    endcase
  end

  assign bx  = {cur_col_r, 2'b00};
  assign by  = {cur_row_r, 2'b00};
  assign wpx = {bw_r, 2'b00};
  assign hpx = {bh_r, 2'b00};

  always_comb begin
    logic [7:0]         m;
    logic signed [3:0]  dx;
    logic signed [3:0]  dy;
    logic signed [11:0] xs1;
    logic               yok;
    for (int h = 0; h < 2; h++) begin
      m  = qmot_r[{blk_row_r[1], 1'(h), 3'b000} +: 8];
      dx = m[7] ? -$signed({1'b0, m[6:4]}) : $signed({1'b0, m[6:4]});
      dy = m[3] ? -$signed({1'b0, m[2:0]}) : $signed({1'b0, m[2:0]});
      xs_h[h] = $signed({2'b00, bx}) + $signed({9'd0, 1'(h), 2'b00}) / 12'sd2 + 12'(dx);
      sy_h[h] = $signed({2'b00, by}) + $signed({9'd0, blk_row_r}) + 11'(dy);
      xs1 = xs_h[h] + 12'sd1;
      yok = !sy_h[h][10] && (sy_h[h] < $signed({2'b00, hpx}));
      v0_h[h]  = yok && !xs_h[h][11] && (xs_h[h] < $signed({2'b00, wpx}));
      v1_h[h]  = yok && !xs1[11] && (xs1 < $signed({2'b00, wpx}));
      off_h[h] = xs_h[h][1:0];
      wc_h[h]  = xs_h[h] >>> 2;
    end
  end

  always_comb begin
    case (state_r)
      S_SRC_L: begin
        mul_y = sy_h[0];
        mul_x = wc_h[0];
      end
      S_SRC_R: begin
        mul_y = sy_h[1];
        mul_x = wc_h[1];
      end
      default: begin
        mul_y = $signed({2'b00, by}) + $signed({9'd0, blk_row_r});
        mul_x = $signed({4'd0, cur_col_r});
      end
    endcase
    prod    = 20'(mul_y) * $signed({12'd0, bw_r});
    addr_s  = 21'(prod) + 21'(mul_x);
    addr_s1 = addr_s + 21'sd1;
    addr_a  = (!addr_s[20] && addr_s < $signed(21'(WORDS))) ? addr_s[AW-1:0] : '0;
    addr_b  = (!addr_s1[20] && addr_s1 < $signed(21'(WORDS))) ? addr_s1[AW-1:0] : '0;
  end

  assign right_pix = resolve_pair(rd_a, rd_b, epoch_r, off_h[1], v0_h[1], v1_h[1]);

  for (genvar c = 0; c < 4; c++) begin : g_lane
    assign old_pix[c] = own_r.cur[8 * c +: 8];
    assign src_pix[c] = (c < 2) ? left_r[8 * (c % 2) +: 8] : right_pix[8 * (c % 2) +: 8];
    bvd_lane #(.LANE(c)) u_lane (
      .it      (item_r),
      .blk_row (blk_row_r),
      .old_pix (old_pix[c]),
      .src_pix (src_pix[c]),
      .new_pix (new_pix[c])
    );
  end

  assign row_word = {new_pix[3], new_pix[2], new_pix[1], new_pix[0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_OWN;
      S_OWN:   state_nxt = S_SRC_L;
      S_SRC_L: state_nxt = S_SRC_R;
      S_SRC_R: state_nxt = S_WR;
      S_WR:    state_nxt = (blk_row_r == 2'd3) ? S_DONE : S_OWN;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    wr       = '0;
    wr_addr  = addr_a;
    unique case (state_r)
      S_CLEAR: begin
        wr.cur_we  = 1'b1;
        wr.prev_we = 1'b1;
        wr_addr    = clr_r;
      end
      S_IDLE: in_stall = 1'b0;
      S_WR: begin
        wr.cur_we  = 1'b1;
        wr.cur_d   = row_word;
        wr.prev_we = (own_r.tag != epoch_r);
        wr.prev_d  = own_r.cur;
        wr.tag_d   = epoch_r;
      end
      default: in_stall = 1'b1;
    endcase
  end

  bvd_frame_mem #(.WORDS(WORDS), .AW(AW)) u_mem (
    .clk       (clk),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      epoch_r     <= '0;
      blk_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (in_acc) begin
        blk_row_r <= '0;
        if (col_eff == 8'd0 && row_eff == 7'd0) begin
          epoch_r <= epoch_r + 16'd1;
        end
      end
      if (state_r == S_WR) begin
        blk_row_r <= blk_row_r + 2'd1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (cur_col_r + 8'd1 >= bw_r) begin
          col_r <= '0;
          row_r <= (cur_row_r + 7'd1 >= bh_r) ? 7'd0 : cur_row_r + 7'd1;
        end else begin
          col_r <= cur_col_r + 8'd1;
          row_r <= cur_row_r;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bw_r        <= bw_eff;
      bh_r        <= bh_eff;
      cur_col_r   <= col_eff;
      cur_row_r   <= row_eff;
      item_r.cmd  <= in_cmd;
      item_r.map  <= map_in;
      item_r.mask <= in_mask;
      item_r.lo   <= in_data_lo;
      item_r.hi   <= in_data_hi;
      item_r.qsel <= qsel_in;
      item_r.qdp  <= qdp_in;
      qmot_r      <= qmot_in;
      bad_r       <= bad_in;
    end
    if (state_r == S_SRC_L) begin
      own_r <= rd_a;
    end
    if (state_r == S_SRC_R) begin
      left_r <= resolve_pair(rd_a, rd_b, epoch_r, off_h[0], v0_h[0], v1_h[0]);
    end
    if (state_r == S_WR) begin
      pix_r[{blk_row_r, 5'd0} +: 32] <= row_word;
    end
    if (state_r == S_DONE && out_free) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_pix_r  <= pix_r;
      out_bad_r  <= bad_r;
      out_last_r <= (cur_col_r == bw_r - 8'd1) && (cur_row_r == bh_r - 7'd1);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_col     = out_col_r;
  assign out_block_row     = out_row_r;
  assign out_pixels_lo     = out_pix_r[63:0];
  assign out_pixels_hi     = out_pix_r[127:64];
  assign out_bad_type      = out_bad_r;
  assign out_last_of_frame = out_last_r;

  a_rise_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished block");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("result during memory clear");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> (cur_col_r < bw_r) && (cur_row_r < bh_r))
    else $error("block position outside frame");

  a_row_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> blk_row_r == 2'd0)
    else $error("block finished with rows left");

endmodule

`default_nettype wire

// ===== rtl/core/bvd_lane.sv =====
// ----------------------------------------------------------------------------
// Block video frame decoder pixel lane
// Works out the new value of one pixel of the current block row.
// ----------------------------------------------------------------------------
`default_nettype none

module bvd_lane #(
  parameter int LANE = 0
) (
  input  bvd_pkg::item_t it,
  input  logic [1:0]     blk_row,
  input  bvd_pkg::pix_t  old_pix,
  input  bvd_pkg::pix_t  src_pix,
  output bvd_pkg::pix_t  new_pix
);
  import bvd_pkg::*;

  logic [1:0]  col;
  logic [3:0]  p;
  logic [1:0]  q;
  logic [1:0]  sel;
  logic [3:0]  qdp;
  logic [4:0]  cnt;
  logic [1:0]  idx;
  logic [15:0] above;

  assign col   = 2'(LANE);
  assign p     = {blk_row, col};
  assign q     = {blk_row[1], col[1]};
  assign sel   = it.qsel[{q, 1'b0} +: 2];
  assign qdp   = it.qdp[{q, 2'b00} +: 4];
  assign above = it.map & ~(16'hFFFF >> p);
  assign cnt   = 5'($countones(above));
  assign idx   = (it.cmd == CMD_PAL_2) ? {1'b0, it.mask[p]} : it.mask[{p, 1'b0} +: 2];

  always_comb begin
    new_pix = old_pix;
    case (it.cmd) inside
      CMD_MASKED, CMD_CMP_0, CMD_CMP_1, CMD_CMP_2, CMD_CMP_3, CMD_CMP_4, CMD_CMP_5: begin
        if (it.map[~p]) begin
          new_pix = data_byte(it.lo, it.hi, cnt[3:0]);
        end
      end
      CMD_SOLID:  new_pix = data_byte(it.lo, it.hi, 4'd0);
      CMD_RAW:    new_pix = data_byte(it.lo, it.hi, p);
      CMD_MOTION: new_pix = src_pix;
      CMD_QUAD: begin
        case (sel)
          QS_SOLID:  new_pix = data_byte(it.lo, it.hi, qdp);
          QS_MOTION: new_pix = src_pix;
          QS_RAW:    new_pix = data_byte(it.lo, it.hi, qdp + {2'b00, blk_row[0], col[0]});
          default:   new_pix = old_pix;
        endcase
      end
      CMD_PAL_2, CMD_PAL_3, CMD_PAL_4: begin
        if (it.cmd == CMD_PAL_3 && idx == 2'd3) begin
          new_pix = 8'd0;
        end else begin
          new_pix = data_byte(it.lo, it.hi, {2'b00, idx});
        end
      end
      default: new_pix = old_pix;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bvd_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Block video frame decoder frame memory
// Current frame, saved frame and per-word epoch tags, one 4-pixel word wide.
// ----------------------------------------------------------------------------
`default_nettype none

module bvd_frame_mem #(
  parameter int WORDS = 76800,
  parameter int AW    = 17
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  input  logic [AW-1:0]     wr_addr,
  input  bvd_pkg::wr_ctl_t  wr,
  output bvd_pkg::word_rd_t rd_a,
  output bvd_pkg::word_rd_t rd_b
);
  import bvd_pkg::*;

  logic [31:0] cur_mem  [WORDS];
  logic [31:0] prev_mem [WORDS];
  logic [15:0] tag_mem  [WORDS];

  always_ff @(posedge clk) begin
    rd_a.cur  <= cur_mem[rd_addr_a];
    rd_a.prev <= prev_mem[rd_addr_a];
    rd_a.tag  <= tag_mem[rd_addr_a];
    rd_b.cur  <= cur_mem[rd_addr_b];
    rd_b.prev <= prev_mem[rd_addr_b];
    rd_b.tag  <= tag_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr.cur_we) begin
      cur_mem[wr_addr] <= wr.cur_d;
    end
    if (wr.prev_we) begin
      prev_mem[wr_addr] <= wr.prev_d;
      tag_mem[wr_addr]  <= wr.tag_d;
    end
  end

endmodule

`default_nettype wire

// ===== sim/block_video_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// Block video frame decoder testbench
// Drives coded 4x4 block items through the decoder under several frame sizes,
// predicts each block's pixels, position and flags from a model of the frame
// store, and checks every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module block_video_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvd_pkg::*;

  localparam int FRAME_BYTES = 640 * 480;

  typedef struct {
    logic [5:0]  cmd;
    logic [31:0] mask;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] mot;
  } blk_code_t;

  typedef struct {
    logic [7:0]  col;
    logic [6:0]  row;
    logic [63:0] plo;
    logic [63:0] phi;
    logic        bad;
    logic        last;
  } blk_pix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  in_cmd = '0;
  logic [31:0] in_mask = '0;
  logic [63:0] in_data_lo = '0;
  logic [63:0] in_data_hi = '0;
  logic [31:0] in_motion = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_block_col;
  logic [6:0]  out_block_row;
  logic [63:0] out_pixels_lo;
  logic [63:0] out_pixels_hi;
  logic        out_bad_type;
  logic        out_last_of_frame;

  block_video_frame_decoder u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit [7:0]  img_now [0:FRAME_BYTES-1];
  bit [7:0]  img_saved [0:FRAME_BYTES-1];
  int        img_extent = 0;
  int        blk_col_pos = 0;
  int        blk_row_pos = 0;
  int        wide_reg = 80;
  int        high_reg = 50;

  blk_code_t pending_blocks [$];
  blk_pix_t  expected_blocks [$];
  blk_code_t driven_block;
  int        n_accepted = 0;
  int        n_checked = 0;
  int        n_frames = 0;
  int        n_bad = 0;
  int        n_errors = 0;

  function automatic bit [7:0] data_at(blk_code_t c, int k);
    k = k & 15;
    return (k < 8) ? c.lo[8*k +: 8] : c.hi[8*(k-8) +: 8];
  endfunction

  function automatic void put_px(int x, int y, int w, bit [7:0] v);
    int a;
    a = y * w + x;
    if (a < FRAME_BYTES) begin
      img_now[a] = v;
      if (a >= img_extent) img_extent = a + 1;
    end
  endfunction

  function automatic bit [7:0] saved_px(int x, int y, int w, int h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 8'd0;
    return img_saved[y * w + x];
  endfunction

  function automatic void shift_square(int x0, int y0, int n, bit [7:0] m, int w, int h);
    int dx;
    int dy;
    dx = m[7] ? -int'(m[6:4]) : int'(m[6:4]);
    dy = m[3] ? -int'(m[2:0]) : int'(m[2:0]);
    for (int y = 0; y < n; y++)
      for (int x = 0; x < n; x++)
        put_px(x0 + x, y0 + y, w, saved_px(x0 + x + dx, y0 + y + dy, w, h));
  endfunction

  function automatic void fill_px(int x0, int y0, int n, int w, bit [7:0] v);
    for (int y = 0; y < n; y++)
      for (int x = 0; x < n; x++)
        put_px(x0 + x, y0 + y, w, v);
  endfunction

  function automatic blk_pix_t decode_block(blk_code_t c);
    blk_pix_t r;
    int bw;
    int bh;
    int w;
    int h;
    int bx;
    int by;
    int dp;
    int mp;
    int s1;
    int s2;
    int a;
    int cnt;
    int idx;
    bit [15:0] map;
    bit [31:0] wide_map;
    bit [7:0]  sel;
    bit [7:0]  pal [0:3];
    bw = (wide_reg < 1) ? 1 : (wide_reg > 160) ? 160 : wide_reg;
    bh = (high_reg < 1) ? 1 : (high_reg > 120) ? 120 : high_reg;
    if (blk_col_pos >= bw) blk_col_pos = 0;
    if (blk_row_pos >= bh) blk_row_pos = 0;
    if (blk_col_pos == 0 && blk_row_pos == 0)
      for (int i = 0; i < img_extent; i++) img_saved[i] = img_now[i];
    w = bw * 4;
    h = bh * 4;
    bx = blk_col_pos * 4;
    by = blk_row_pos * 4;
    dp = 0;
    mp = 0;
    r.bad = 1'b0;
    case (c.cmd)
      CMD_SKIP, CMD_SKIP_ALT: ;
      CMD_MASKED, CMD_CMP_0, CMD_CMP_1, CMD_CMP_2, CMD_CMP_3, CMD_CMP_4, CMD_CMP_5: begin
        if (c.cmd == CMD_MASKED) begin
          map = c.mask[15:0];
        end else begin
          case (c.cmd)
            CMD_CMP_0: begin s1 = 0; s2 = 0; end
            CMD_CMP_1: begin s1 = 8; s2 = 0; end
            CMD_CMP_2: begin s1 = 8; s2 = 8; end
            CMD_CMP_3: begin s1 = 8; s2 = 4; end
            CMD_CMP_4: begin s1 = 4; s2 = 0; end
            default: begin s1 = 4; s2 = 4; end
          endcase
          wide_map = ({24'd0, c.mask[7:4], 4'd0} << s1) | ({28'd0, c.mask[3:0]} << s2);
          map = wide_map[15:0];
        end
        for (int p = 0; p < 16; p++) begin
          if (map[15]) begin
            put_px(bx + p % 4, by + p / 4, w, data_at(c, dp));
            dp++;
          end
          map = map << 1;
        end
      end
      CMD_SOLID: fill_px(bx, by, 4, w, data_at(c, 0));
      CMD_RAW: for (int p = 0; p < 16; p++) put_px(bx + p % 4, by + p / 4, w, data_at(c, p));
      CMD_MOTION: shift_square(bx, by, 4, c.mot[7:0], w, h);
      CMD_QUAD: begin
        sel = c.mask[7:0];
        for (int q = 0; q < 4; q++) begin
          case (sel[7:6])
            QS_SOLID: begin
              fill_px(bx + 2 * (q % 2), by + 2 * (q / 2), 2, w, data_at(c, dp));
              dp++;
            end
            QS_MOTION: begin
              shift_square(bx + 2 * (q % 2), by + 2 * (q / 2), 2, c.mot[8 * (mp % 4) +: 8], w, h);
              mp++;
            end
            QS_RAW: begin
              for (int p = 0; p < 4; p++) begin
                put_px(bx + 2 * (q % 2) + p % 2, by + 2 * (q / 2) + p / 2, w, data_at(c, dp));
                dp++;
              end
            end
            default: ;
          endcase
          sel = sel << 2;
        end
      end
      CMD_PAL_2, CMD_PAL_3, CMD_PAL_4: begin
        cnt = int'(c.cmd) - 30;
        for (int k = 0; k < 4; k++) pal[k] = (k < cnt) ? data_at(c, k) : 8'd0;
        for (int p = 0; p < 16; p++) begin
          idx = (cnt == 2) ? int'(c.mask[p]) : int'(c.mask[2 * p +: 2]);
          put_px(bx + p % 4, by + p / 4, w, pal[idx]);
        end
      end
      default: r.bad = 1'b1;
    endcase
    for (int p = 0; p < 16; p++) begin
      a = (by + p / 4) * w + bx + p % 4;
      if (p < 8) r.plo[8 * p +: 8] = (a < FRAME_BYTES) ? img_now[a] : 8'd0;
      else r.phi[8 * (p - 8) +: 8] = (a < FRAME_BYTES) ? img_now[a] : 8'd0;
    end
    r.col = blk_col_pos[7:0];
    r.row = blk_row_pos[6:0];
    r.last = (blk_col_pos == bw - 1 && blk_row_pos == bh - 1);
    blk_col_pos++;
    if (blk_col_pos >= bw) begin
      blk_col_pos = 0;
      blk_row_pos++;
      if (blk_row_pos >= bh) blk_row_pos = 0;
    end
    return r;
  endfunction

  function automatic bit take_break();
    if (n_accepted >= 700 && n_accepted < 1000) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(decode_block(driven_block));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_blocks.size() > 0 && !take_break()) begin
          driven_block = pending_blocks.pop_front();
          in_valid   <= 1'b1;
          in_cmd     <= driven_block.cmd;
          in_mask    <= driven_block.mask;
          in_data_lo <= driven_block.lo;
          in_data_hi <= driven_block.hi;
          in_motion  <= driven_block.mot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    blk_pix_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result col %0d row %0d", $time, out_block_col,
                   out_block_row);
          n_errors++;
        end else begin
          e = expected_blocks.pop_front();
          n_checked++;
          if (out_last_of_frame) n_frames++;
          if (out_bad_type) n_bad++;
          if (out_block_col !== e.col || out_block_row !== e.row ||
              out_pixels_lo !== e.plo || out_pixels_hi !== e.phi ||
              out_bad_type !== e.bad || out_last_of_frame !== e.last) begin
            $display("%0t: mismatch exp col %0d row %0d px %h_%h bad %b last %b", $time,
                     e.col, e.row, e.phi, e.plo, e.bad, e.last);
            $display("%0t:          got col %0d row %0d px %h_%h bad %b last %b", $time,
                     out_block_col, out_block_row, out_pixels_hi, out_pixels_lo,
                     out_bad_type, out_last_of_frame);
            n_errors++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[7:0];
    if (idx) high_reg = value & 8'h7F;
    else wide_reg = value & 8'hFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_block(logic [5:0] cmd, logic [31:0] mask, logic [63:0] lo,
                             logic [63:0] hi, logic [31:0] mot);
    blk_code_t c;
    c.cmd = cmd;
    c.mask = mask;
    c.lo = lo;
    c.hi = hi;
    c.mot = mot;
    pending_blocks.push_back(c);
  endtask

  task automatic queue_random(int n);
    logic [5:0] codes [0:15];
    logic [5:0] cmd;
    codes = '{CMD_SKIP, CMD_MASKED, CMD_SOLID, CMD_RAW, CMD_MOTION, CMD_SKIP_ALT, CMD_QUAD,
              CMD_CMP_0, CMD_CMP_1, CMD_CMP_2, CMD_CMP_3, CMD_CMP_4, CMD_CMP_5,
              CMD_PAL_2, CMD_PAL_3, CMD_PAL_4};
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < 10) ? 6'($urandom_range(63)) : codes[$urandom_range(15)];
      queue_block(cmd, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin
    int sizes [0:7][0:1];
    sizes = '{'{1, 1}, '{0, 0}, '{255, 127}, '{160, 120}, '{2, 5}, '{7, 1}, '{1, 6}, '{3, 3}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    write_reg(1'b0, 4);
    write_reg(1'b1, 3);
    queue_block(CMD_SKIP, '1, '1, '1, '1);
    queue_block(CMD_RAW, '0, 64'h0706050403020100, 64'h0F0E0D0C0B0A0908, '0);
    queue_block(CMD_SKIP_ALT, '0, '0, '0, '0);
    queue_block(CMD_MASKED, 32'hFFFF_A5A5, '1, '1, '0);
    queue_block(CMD_MASKED, 32'h0000_0000, '1, '1, '0);
    queue_block(CMD_CMP_0, 32'h5A, 64'h1122334455667788, 64'h99AABBCCDDEEFF00, '0);
    queue_block(CMD_CMP_1, 32'hC3, 64'h1122334455667788, '0, '0);
    queue_block(CMD_CMP_2, 32'hFF, '1, '0, '0);
    queue_block(CMD_CMP_3, 32'h81, 64'hA0B0C0D0E0F01020, '0, '0);
    queue_block(CMD_CMP_4, 32'h3C, 64'h0102030405060708, '0, '0);
    queue_block(CMD_CMP_5, 32'hF0, 64'hFFEEDDCCBBAA9988, '0, '0);
    queue_block(CMD_SOLID, '0, 64'hFF, '0, '0);
    queue_block(CMD_SOLID, '0, 64'h00, '0, '0);
    queue_block(CMD_MOTION, '0, '0, '0, 32'h77);
    queue_block(CMD_MOTION, '0, '0, '0, 32'hFF);
    queue_block(CMD_MOTION, '0, '0, '0, 32'h88);
    queue_block(CMD_QUAD, 32'hE4, {$urandom, $urandom}, {$urandom, $urandom}, 32'h8F7F1F99);
    queue_block(CMD_QUAD, 32'h1B, {$urandom, $urandom}, {$urandom, $urandom}, 32'hF0F70A00);
    queue_block(CMD_PAL_2, 32'hAAAA_5555, 64'h80FF, '0, '0);
    queue_block(CMD_PAL_3, '1, 64'h333231, '0, '0);
    queue_block(CMD_PAL_3, 32'h1B1B_E4E4, 64'h333231, '0, '0);
    queue_block(CMD_PAL_4, 32'hE4E4_1B1B, 64'h44434241, '0, '0);
    queue_block(6'd63, '1, '1, '1, '1);
    queue_block(6'd6, '0, '0, '0, '0);
    wait_drained();
    for (int p = 0; p < 16; p++) begin
      if (p < 8) begin
        write_reg(1'b0, sizes[p][0]);
        write_reg(1'b1, sizes[p][1]);
      end else begin
        write_reg(1'b0, $urandom_range(1, 8));
        write_reg(1'b1, $urandom_range(1, 6));
      end
      queue_random(p == 15 ? 0 : 130);
      wait_drained();
    end
    write_reg(1'b0, 80);
    write_reg(1'b1, 50);
    queue_random(25);
    wait_drained();
    $display("Checked %0d blocks under 17 frame sizes: %0d frame ends, %0d unknown types.",
             n_checked, n_frames, n_bad);
    if (n_errors == 0 && expected_blocks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d blocks outstanding.", expected_blocks.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
